// File: rtl/perspective_barycentric_weights_macros.svh
// Assertion macros for the perspective barycentric weights block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef PERSPECTIVE_BARYCENTRIC_WEIGHTS_MACROS_SVH
`define PERSPECTIVE_BARYCENTRIC_WEIGHTS_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is high.
`define PBW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds across reset.
`define PBW_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBW_ASSERT(lbl, clk, rst, prop, msg)
`define PBW_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/pbw_pkg.sv
// Shared types, widths and helper functions of the perspective barycentric weights block.
// No dependencies; used by every other RTL file but the macro header.
package pbw_pkg;

   localparam int XY_W    = 16;
   localparam int W_W     = 32;
   localparam int EPS_W   = 16;
   localparam int WT_W    = 20;
   localparam int Q_W     = WT_W;
   localparam int EDGE_W  = XY_W + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int E_W     = CROSS_W + 2;

   localparam int D1_DEN_W = CROSS_W - 1;
   localparam int D1_NUM_W = D1_DEN_W + 4;

   localparam int P_W      = W_W + WT_W;
   localparam int NORM_W   = P_W + 2;
   localparam int D2_DEN_W = P_W;
   localparam int D2_NUM_W = D2_DEN_W + 4;

   localparam int INT_STEPS  = 4;
   localparam int FRAC_STEPS = 16;
   localparam int DIV_STEPS  = INT_STEPS + FRAC_STEPS;

   localparam logic signed [WT_W-1:0] WT_MAX    = {1'b0, {(WT_W-1){1'b1}}};
   localparam logic signed [WT_W-1:0] WT_MIN    = {1'b1, {(WT_W-1){1'b0}}};
   localparam logic [Q_W-1:0]         NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [EPS_W-1:0]       EPS_RESET = EPS_W'(1);

   typedef struct packed {
      logic signed [XY_W-1:0] v0_x;
      logic signed [XY_W-1:0] v0_y;
      logic signed [W_W-1:0]  v0_w;
      logic signed [XY_W-1:0] v1_x;
      logic signed [XY_W-1:0] v1_y;
      logic signed [W_W-1:0]  v1_w;
      logic signed [XY_W-1:0] v2_x;
      logic signed [XY_W-1:0] v2_y;
      logic signed [W_W-1:0]  v2_w;
      logic signed [XY_W-1:0] pixel_x;
      logic signed [XY_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [WT_W-1:0] screen_w0;
      logic signed [WT_W-1:0] screen_w1;
      logic signed [WT_W-1:0] screen_w2;
      logic signed [WT_W-1:0] persp_w0;
      logic signed [WT_W-1:0] persp_w1;
      logic signed [WT_W-1:0] persp_w2;
      logic                   inside_res;
      logic                   degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][W_W-1:0] w;
      logic [2:0]          neg;
      logic [2:0]          sat;
      logic                degen;
   } side1_type;

   typedef struct packed {
      logic [2:0][WT_W-1:0] sw;
      logic [2:0]           neg;
      logic [2:0]           sat;
      logic                 degen;
   } side2_type;

   // Quotient magnitude plus sign and overflow flag to a saturated Q4.16 weight.
   function automatic logic signed [WT_W-1:0] sat_weight(input logic [Q_W-1:0] q,
                                                         input logic neg,
                                                         input logic sat);
      logic signed [WT_W-1:0] res;
      if (sat) begin
         res = neg ? WT_MIN : WT_MAX;
      end else if (neg) begin
         res = (q > NEG_LIMIT) ? WT_MIN : $signed(Q_W'(0) - q);
      end else begin
         res = q[Q_W-1] ? WT_MAX : $signed(q);
      end
      return res;
   endfunction

endpackage

// File: rtl/pbw_req_if.sv
// Sample request channel: valid, ready and one triangle plus sample point.
// Depends on pbw_pkg.
interface pbw_req_if;
   logic              valid;
   logic              ready;
   pbw_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pbw_rsp_if.sv
// Weight response channel: valid, ready and one set of weights and flags.
// Depends on pbw_pkg.
interface pbw_rsp_if;
   logic              valid;
   logic              ready;
   pbw_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pbw_csr_if.sv
// Register write channel for the inside-test epsilon.
// Depends on pbw_pkg.
interface pbw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pbw_pkg::EPS_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pbw_setup.sv
// Edge vectors, cross products, area and numerators, magnitudes and overflow flags.
// Six pipeline stages; depends on pbw_pkg.
module pbw_setup (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  pbw_pkg::req_type                      in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [2:0][pbw_pkg::D1_NUM_W-1:0]     out_num,
   output logic [pbw_pkg::D1_DEN_W-1:0]          out_den,
   output pbw_pkg::side1_type                    out_side
);
   localparam int STAGES = 6;
   localparam int EW  = pbw_pkg::EDGE_W;
   localparam int PW  = pbw_pkg::PROD_W;
   localparam int CW  = pbw_pkg::CROSS_W;
   localparam int E_W = pbw_pkg::E_W;
   localparam int NW  = pbw_pkg::D1_NUM_W;
   localparam int DW  = pbw_pkg::D1_DEN_W;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES:0]   rdy;

   logic [2:0][pbw_pkg::W_W-1:0] w_ff [STAGES];

   logic signed [EW-1:0] abx_ff, aby_ff, acx_ff, acy_ff, apx_ff, apy_ff;
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [CW-1:0] area2_ff, e1_ff, e2_ff;
   logic signed [E_W-1:0] e3_ff [3];
   logic signed [CW-1:0] area3_ff;
   logic [2:0][NW-1:0]   mag4_ff;
   logic [DW-1:0]        den4_ff;
   logic [2:0]           neg4_ff;
   logic                 degen4_ff;
   logic [2:0][NW-1:0]   num5_ff;
   logic [DW-1:0]        den5_ff;
   logic [2:0]           neg5_ff;
   logic [2:0]           sat5_ff;
   logic                 degen5_ff;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= (i == 0) ? in_valid : vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         abx_ff  <= EW'(in_data.v1_x) - EW'(in_data.v0_x);
         aby_ff  <= EW'(in_data.v1_y) - EW'(in_data.v0_y);
         acx_ff  <= EW'(in_data.v2_x) - EW'(in_data.v0_x);
         acy_ff  <= EW'(in_data.v2_y) - EW'(in_data.v0_y);
         apx_ff  <= EW'(in_data.pixel_x) - EW'(in_data.v0_x);
         apy_ff  <= EW'(in_data.pixel_y) - EW'(in_data.v0_y);
         w_ff[0] <= {in_data.v2_w, in_data.v1_w, in_data.v0_w};
      end
      for (int i = 1; i < STAGES; i++) begin
         if (rdy[i]) begin
            w_ff[i] <= w_ff[i-1];
         end
      end
      if (rdy[1]) begin
         m0_ff <= PW'(abx_ff) * PW'(acy_ff);
         m1_ff <= PW'(aby_ff) * PW'(acx_ff);
         m2_ff <= PW'(acy_ff) * PW'(apx_ff);
         m3_ff <= PW'(acx_ff) * PW'(apy_ff);
         m4_ff <= PW'(abx_ff) * PW'(apy_ff);
         m5_ff <= PW'(aby_ff) * PW'(apx_ff);
      end
      if (rdy[2]) begin
         area2_ff <= CW'(m0_ff) - CW'(m1_ff);
         e1_ff    <= CW'(m2_ff) - CW'(m3_ff);
         e2_ff    <= CW'(m4_ff) - CW'(m5_ff);
      end
      if (rdy[3]) begin
         e3_ff[0] <= E_W'(area2_ff) - E_W'(e1_ff) - E_W'(e2_ff);
         e3_ff[1] <= E_W'(e1_ff);
         e3_ff[2] <= E_W'(e2_ff);
         area3_ff <= area2_ff;
      end
      if (rdy[4]) begin
         for (int i = 0; i < 3; i++) begin
            mag4_ff[i] <= e3_ff[i][E_W-1] ? NW'(-e3_ff[i]) : NW'(e3_ff[i]);
            neg4_ff[i] <= e3_ff[i][E_W-1] ^ area3_ff[CW-1];
         end
         den4_ff   <= area3_ff[CW-1] ? DW'(-area3_ff) : DW'(area3_ff);
         degen4_ff <= (area3_ff == '0);
      end
      if (rdy[5]) begin
         for (int i = 0; i < 3; i++) begin
            sat5_ff[i] <= mag4_ff[i] >= (NW'(den4_ff) << 4);
         end
         num5_ff   <= mag4_ff;
         den5_ff   <= den4_ff;
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
      end
   end

   assign in_ready       = rdy[0];
   assign out_valid      = vld_ff[STAGES-1];
   assign out_num        = num5_ff;
   assign out_den        = den5_ff;
   assign out_side.w     = w_ff[STAGES-1];
   assign out_side.neg   = neg5_ff;
   assign out_side.sat   = sat5_ff;
   assign out_side.degen = degen5_ff;

endmodule

// File: rtl/pbw_div.sv
// Three-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Gives floor(num * 2^16 / den) for num < 16 * den; depends on pbw_pkg.
module pbw_div #(
   parameter int NUM_W  = pbw_pkg::D1_NUM_W,
   parameter int DEN_W  = pbw_pkg::D1_DEN_W,
   parameter int SIDE_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [2:0][NUM_W-1:0]            in_num,
   input  logic [DEN_W-1:0]                 in_den,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [2:0][pbw_pkg::Q_W-1:0]     out_q,
   output logic [SIDE_W-1:0]                out_side
);
   localparam int STEPS = pbw_pkg::DIV_STEPS;
   localparam int ISTEP = pbw_pkg::INT_STEPS;
   localparam int QW    = pbw_pkg::Q_W;
   localparam int RW    = NUM_W + 1;

   logic                 vld_ff  [STEPS];
   logic                 rdy     [STEPS+1];
   logic [2:0][RW-1:0]   rem_ff  [STEPS];
   logic [2:0][QW-1:0]   q_ff    [STEPS];
   logic [DEN_W-1:0]     den_ff  [STEPS];
   logic [SIDE_W-1:0]    side_ff [STEPS];

   assign rdy[STEPS] = out_ready;

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic               vld_prev;
      logic [2:0][RW-1:0] rem_prev;
      logic [2:0][QW-1:0] q_prev;
      logic [DEN_W-1:0]   den_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic [RW-1:0]      trial;
      logic [2:0][RW-1:0] rem_in;
      logic [2:0][QW-1:0] q_in;

      if (s == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign den_prev  = in_den;
         assign side_prev = in_side;
         assign q_prev    = '0;
         for (genvar l = 0; l < 3; l++) begin : g_load
            assign rem_prev[l] = RW'(in_num[l]);
         end
      end else begin : g_next
         assign vld_prev  = vld_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign q_prev    = q_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      // integer bits compare against the shifted divisor, fraction bits shift the remainder
      if (s < ISTEP) begin : g_int
         assign trial = RW'(den_prev) << (ISTEP - 1 - s);
      end else begin : g_frac
         assign trial = RW'(den_prev);
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RW-1:0] part;
         logic          ge;
         if (s < ISTEP) begin : g_keep
            assign part = rem_prev[l];
         end else begin : g_shift
            assign part = {rem_prev[l][RW-2:0], 1'b0};
         end
         assign ge        = part >= trial;
         assign rem_in[l] = ge ? part - trial : part;
         assign q_in[l]   = {q_prev[l][QW-2:0], ge};
      end

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[STEPS-1];
   assign out_q     = q_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: rtl/pbw_norm.sv
// Screen weight saturation, w products, normalizer, magnitudes and overflow flags.
// Five pipeline stages; depends on pbw_pkg.
module pbw_norm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [2:0][pbw_pkg::Q_W-1:0]          in_q,
   input  pbw_pkg::side1_type                    in_side,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [2:0][pbw_pkg::D2_NUM_W-1:0]     out_num,
   output logic [pbw_pkg::D2_DEN_W-1:0]          out_den,
   output pbw_pkg::side2_type                    out_side
);
   localparam int STAGES = 5;
   localparam int WW = pbw_pkg::WT_W;
   localparam int PW = pbw_pkg::P_W;
   localparam int SW = pbw_pkg::NORM_W;
   localparam int NW = pbw_pkg::D2_NUM_W;
   localparam int DW = pbw_pkg::D2_DEN_W;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES:0]   rdy;

   logic [2:0][WW-1:0]          sw_ff    [STAGES];
   logic                        degen_ff [STAGES];
   logic [2:0][pbw_pkg::W_W-1:0] w0_ff;
   logic signed [PW-1:0]        p1_ff [3];
   logic signed [PW-1:0]        p2_ff [3];
   logic signed [SW-1:0]        norm2_ff;
   logic [2:0][NW-1:0]          pmag3_ff;
   logic [DW-1:0]               nmag3_ff;
   logic [2:0]                  neg3_ff;
   logic [2:0][NW-1:0]          num4_ff;
   logic [DW-1:0]               den4_ff;
   logic [2:0]                  neg4_ff;
   logic [2:0]                  sat4_ff;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= (i == 0) ? in_valid : vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            sw_ff[0][i] <= pbw_pkg::sat_weight(in_q[i], in_side.neg[i], in_side.sat[i]);
         end
         w0_ff       <= in_side.w;
         degen_ff[0] <= in_side.degen;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (rdy[i]) begin
            sw_ff[i] <= sw_ff[i-1];
         end
      end
      for (int i = 1; i < 3; i++) begin
         if (rdy[i]) begin
            degen_ff[i] <= degen_ff[i-1];
         end
      end
      if (rdy[1]) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= PW'($signed(w0_ff[i])) * PW'($signed(sw_ff[0][i]));
         end
      end
      if (rdy[2]) begin
         p2_ff    <= p1_ff;
         norm2_ff <= SW'(p1_ff[0]) + SW'(p1_ff[1]) + SW'(p1_ff[2]);
      end
      if (rdy[3]) begin
         for (int i = 0; i < 3; i++) begin
            pmag3_ff[i] <= p2_ff[i][PW-1] ? NW'(-p2_ff[i]) : NW'(p2_ff[i]);
            neg3_ff[i]  <= p2_ff[i][PW-1] ^ norm2_ff[SW-1];
         end
         nmag3_ff    <= norm2_ff[SW-1] ? DW'(-norm2_ff) : DW'(norm2_ff);
         degen_ff[3] <= degen_ff[2] || (norm2_ff == '0);
      end
      if (rdy[4]) begin
         for (int i = 0; i < 3; i++) begin
            sat4_ff[i] <= pmag3_ff[i] >= (NW'(nmag3_ff) << 4);
         end
         num4_ff     <= pmag3_ff;
         den4_ff     <= nmag3_ff;
         neg4_ff     <= neg3_ff;
         degen_ff[4] <= degen_ff[3];
      end
   end

   assign in_ready       = rdy[0];
   assign out_valid      = vld_ff[STAGES-1];
   assign out_num        = num4_ff;
   assign out_den        = den4_ff;
   assign out_side.sw    = sw_ff[STAGES-1];
   assign out_side.neg   = neg4_ff;
   assign out_side.sat   = sat4_ff;
   assign out_side.degen = degen_ff[STAGES-1];

endmodule

// File: rtl/perspective_barycentric_weights.sv
// Perspective-correct barycentric weights, top level.
// Depends on pbw_pkg, the channel interfaces, pbw_setup, pbw_div, pbw_norm and the macro header.
//
// Channels: req_ch takes one triangle (x, y in Q12.4, w in Q16.16) and a sample point per
// transaction; rsp_ch returns one transaction per request, in order: screen and perspective
// weights in saturated Q4.16, an inside flag and a degenerate flag. csr_ch writes the 16-bit
// inside-test epsilon; it is always ready and should only be written while the block is idle.
// Pipeline: 6 setup stages, 20 divider stages, 5 normalizer stages, 20 divider stages and
// 2 output stages from request acceptance to response valid. Throughput: one transaction
// per cycle while rsp_ch.ready holds, set by the one-quotient-bit-per-stage divider pipelines.
// Every stage has a valid bit and a ready chain, so empty stages fill while the response
// waits; when the receiver stalls and the pipeline is full, req_ch.ready drops and nothing
// is lost or repeated.
// Reset clears all valid bits and sets epsilon to 1.
`include "perspective_barycentric_weights_macros.svh"
module perspective_barycentric_weights (
   input logic        clock,
   input logic        reset,
   pbw_req_if.sink    req_ch,
   pbw_rsp_if.source  rsp_ch,
   pbw_csr_if.sink    csr_ch
);
   localparam int STAGES = 2;
   localparam int WW = pbw_pkg::WT_W;
   localparam int EW = pbw_pkg::EPS_W;

   logic                                 su_valid, su_ready;
   logic [2:0][pbw_pkg::D1_NUM_W-1:0]    su_num;
   logic [pbw_pkg::D1_DEN_W-1:0]         su_den;
   pbw_pkg::side1_type                   su_side;
   logic                                 d1_valid, d1_ready;
   logic [2:0][pbw_pkg::Q_W-1:0]         d1_q;
   pbw_pkg::side1_type                   d1_side;
   logic                                 nm_valid, nm_ready;
   logic [2:0][pbw_pkg::D2_NUM_W-1:0]    nm_num;
   logic [pbw_pkg::D2_DEN_W-1:0]         nm_den;
   pbw_pkg::side2_type                   nm_side;
   logic                                 d2_valid;
   logic [2:0][pbw_pkg::Q_W-1:0]         d2_q;
   pbw_pkg::side2_type                   d2_side;

   logic [EW-1:0]       eps_ff;
   logic [STAGES-1:0]   vld_ff;
   logic [STAGES:0]     rdy;
   logic [2:0][WW-1:0]  pw0_ff;
   logic [2:0][WW-1:0]  sw0_ff;
   logic                degen0_ff;
   logic [2:0]          pos_ok;
   pbw_pkg::rsp_type    rsp_ff;

   pbw_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_ch.data),
      .out_valid (su_valid),
      .out_ready (su_ready),
      .out_num   (su_num),
      .out_den   (su_den),
      .out_side  (su_side)
   );

   pbw_div #(
      .NUM_W  (pbw_pkg::D1_NUM_W),
      .DEN_W  (pbw_pkg::D1_DEN_W),
      .SIDE_W ($bits(pbw_pkg::side1_type))
   ) u_div_screen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (su_valid),
      .in_ready  (su_ready),
      .in_num    (su_num),
      .in_den    (su_den),
      .in_side   (su_side),
      .out_valid (d1_valid),
      .out_ready (d1_ready),
      .out_q     (d1_q),
      .out_side  (d1_side)
   );

   pbw_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_ready  (d1_ready),
      .in_q      (d1_q),
      .in_side   (d1_side),
      .out_valid (nm_valid),
      .out_ready (nm_ready),
      .out_num   (nm_num),
      .out_den   (nm_den),
      .out_side  (nm_side)
   );

   pbw_div #(
      .NUM_W  (pbw_pkg::D2_NUM_W),
      .DEN_W  (pbw_pkg::D2_DEN_W),
      .SIDE_W ($bits(pbw_pkg::side2_type))
   ) u_div_persp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nm_valid),
      .in_ready  (nm_ready),
      .in_num    (nm_num),
      .in_den    (nm_den),
      .in_side   (nm_side),
      .out_valid (d2_valid),
      .out_ready (rdy[0]),
      .out_q     (d2_q),
      .out_side  (d2_side)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= pbw_pkg::EPS_RESET;
      end else if (csr_ch.valid) begin
         eps_ff <= csr_ch.data;
      end
   end

   always_comb begin
      rdy[STAGES] = rsp_ch.ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= (i == 0) ? d2_valid : vld_ff[i-1];
            end
         end
      end
   end

   // pw + eps >= 0 is pw >= -eps
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [WW:0] sum;
         sum       = {pw0_ff[i][WW-1], pw0_ff[i]} + (WW+1)'(eps_ff);
         pos_ok[i] = !sum[WW];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            pw0_ff[i] <= pbw_pkg::sat_weight(d2_q[i], d2_side.neg[i], d2_side.sat[i]);
         end
         sw0_ff    <= d2_side.sw;
         degen0_ff <= d2_side.degen;
      end
      if (rdy[1]) begin
         rsp_ff.screen_w0  <= degen0_ff ? '0 : $signed(sw0_ff[0]);
         rsp_ff.screen_w1  <= degen0_ff ? '0 : $signed(sw0_ff[1]);
         rsp_ff.screen_w2  <= degen0_ff ? '0 : $signed(sw0_ff[2]);
         rsp_ff.persp_w0   <= degen0_ff ? '0 : $signed(pw0_ff[0]);
         rsp_ff.persp_w1   <= degen0_ff ? '0 : $signed(pw0_ff[1]);
         rsp_ff.persp_w2   <= degen0_ff ? '0 : $signed(pw0_ff[2]);
         rsp_ff.inside_res <= !degen0_ff && (&pos_ok);
         rsp_ff.degenerate <= degen0_ff;
      end
   end

   assign rsp_ch.valid = vld_ff[STAGES-1];
   assign rsp_ch.data  = rsp_ff;

   `PBW_ASSERT(a_degen_zero, clock, reset, vld_ff[1] && rsp_ff.degenerate |-> !rsp_ff.inside_res && rsp_ff.persp_w0 == '0 && rsp_ff.persp_w1 == '0 && rsp_ff.persp_w2 == '0 && rsp_ff.screen_w0 == '0, "degenerate transaction with nonzero weights or inside set")
   `PBW_ASSERT(a_nonneg_inside, clock, reset, vld_ff[1] && !rsp_ff.degenerate && !rsp_ff.persp_w0[WW-1] && !rsp_ff.persp_w1[WW-1] && !rsp_ff.persp_w2[WW-1] |-> rsp_ff.inside_res, "nonnegative weights but sample not inside")
   `PBW_ASSERT(a_out_hold, clock, reset, vld_ff[1] && !rsp_ch.ready |=> vld_ff[1] && $stable(rsp_ff), "stalled response changed")
   `PBW_ASSERT_NORST(a_rst_clear, clock, reset |=> !vld_ff[0] && !vld_ff[1], "output stages valid after reset")

endmodule

// File: tb/perspective_barycentric_weights_test.sv
// Self-checking test of perspective_barycentric_weights: a queue-fed driver, a monitor and
// an in-bench weight predictor, run over several epsilon settings and idle patterns.
// Depends on pbw_pkg, the three channel interfaces and the block itself.
module perspective_barycentric_weights_test;

   localparam int LATENCY = 53;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbw_req_if req_ch ();
   pbw_rsp_if rsp_ch ();
   pbw_csr_if csr_ch ();

   perspective_barycentric_weights dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #2 clock = ~clock;

   pbw_pkg::req_type    pending_samples[$];
   pbw_pkg::rsp_type    expected_weights[$];
   logic [pbw_pkg::EPS_W-1:0] model_epsilon;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         error_count = 0;
   logic       csr_write_go = 1'b0;
   logic [pbw_pkg::EPS_W-1:0] csr_write_value = '0;

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // num * 2^16 / den, truncated toward zero, saturated to Q4.16
   function automatic logic signed [pbw_pkg::WT_W-1:0] q16_quotient(longint num, longint den);
      logic neg;
      longint unsigned a, b, q, r;
      neg = (num < 0) != (den < 0);
      a = abs64(num);
      b = abs64(den);
      if (a >= (b << 4)) return neg ? pbw_pkg::WT_MIN : pbw_pkg::WT_MAX;
      q = a / b;
      r = a % b;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q = q | 1;
         end
      end
      if (neg) return (q > 524288) ? pbw_pkg::WT_MIN : pbw_pkg::WT_W'(-longint'(q));
      return (q > 524287) ? pbw_pkg::WT_MAX : pbw_pkg::WT_W'(q);
   endfunction

   function automatic pbw_pkg::rsp_type predict_weights(pbw_pkg::req_type s,
                                                        logic [pbw_pkg::EPS_W-1:0] eps);
      pbw_pkg::rsp_type o;
      longint abx, aby, acx, acy, apx, apy, area, e0, e1, e2, p0, p1, p2, norm;
      longint neps;
      o = '0;
      o.degenerate = 1'b1;
      abx = longint'(s.v1_x) - s.v0_x;
      aby = longint'(s.v1_y) - s.v0_y;
      acx = longint'(s.v2_x) - s.v0_x;
      acy = longint'(s.v2_y) - s.v0_y;
      apx = longint'(s.pixel_x) - s.v0_x;
      apy = longint'(s.pixel_y) - s.v0_y;
      area = abx * acy - aby * acx;
      if (area != 0) begin
         e1 = acy * apx - acx * apy;
         e2 = abx * apy - aby * apx;
         e0 = area - e1 - e2;
         o.screen_w0 = q16_quotient(e0, area);
         o.screen_w1 = q16_quotient(e1, area);
         o.screen_w2 = q16_quotient(e2, area);
         p0 = longint'(s.v0_w) * longint'(o.screen_w0);
         p1 = longint'(s.v1_w) * longint'(o.screen_w1);
         p2 = longint'(s.v2_w) * longint'(o.screen_w2);
         norm = p0 + p1 + p2;
         if (norm != 0) begin
            o.persp_w0 = q16_quotient(p0, norm);
            o.persp_w1 = q16_quotient(p1, norm);
            o.persp_w2 = q16_quotient(p2, norm);
            o.degenerate = 1'b0;
            neps = -longint'(eps);
            o.inside_res = (longint'(o.persp_w0) >= neps) && (longint'(o.persp_w1) >= neps)
                        && (longint'(o.persp_w2) >= neps);
         end else begin
            o.screen_w0 = '0;
            o.screen_w1 = '0;
            o.screen_w2 = '0;
         end
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) expected_weights.push_back(predict_weights(req_ch.data, model_epsilon));
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data  <= pending_samples.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_ch.valid <= 1'b0;
         csr_ch.data  <= '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) model_epsilon = csr_ch.data;
         csr_ch.valid <= csr_write_go && !(csr_ch.valid && csr_ch.ready);
         csr_ch.data  <= csr_write_value;
      end
   end

   // monitor
   always @(posedge clock) begin
      pbw_pkg::rsp_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_weights.size() == 0) begin
               $error("unexpected transaction %h", rsp_ch.data);
               error_count++;
            end else begin
               e = expected_weights.pop_front();
               if (rsp_ch.data.screen_w0 !== e.screen_w0) begin
                  $error("screen_w0 exp %0d got %0d", e.screen_w0, rsp_ch.data.screen_w0);
                  error_count++;
               end
               if (rsp_ch.data.screen_w1 !== e.screen_w1) begin
                  $error("screen_w1 exp %0d got %0d", e.screen_w1, rsp_ch.data.screen_w1);
                  error_count++;
               end
               if (rsp_ch.data.screen_w2 !== e.screen_w2) begin
                  $error("screen_w2 exp %0d got %0d", e.screen_w2, rsp_ch.data.screen_w2);
                  error_count++;
               end
               if (rsp_ch.data.persp_w0 !== e.persp_w0) begin
                  $error("persp_w0 exp %0d got %0d", e.persp_w0, rsp_ch.data.persp_w0);
                  error_count++;
               end
               if (rsp_ch.data.persp_w1 !== e.persp_w1) begin
                  $error("persp_w1 exp %0d got %0d", e.persp_w1, rsp_ch.data.persp_w1);
                  error_count++;
               end
               if (rsp_ch.data.persp_w2 !== e.persp_w2) begin
                  $error("persp_w2 exp %0d got %0d", e.persp_w2, rsp_ch.data.persp_w2);
                  error_count++;
               end
               if (rsp_ch.data.inside_res !== e.inside_res) begin
                  $error("inside_res exp %0b got %0b", e.inside_res, rsp_ch.data.inside_res);
                  error_count++;
               end
               if (rsp_ch.data.degenerate !== e.degenerate) begin
                  $error("degenerate exp %0b got %0b", e.degenerate, rsp_ch.data.degenerate);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic pbw_pkg::req_type random_sample();
      pbw_pkg::req_type s;
      int span;
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(5))
         0, 1, 2: begin
            // raster-like triangle with sample near it and nonnegative w
            span = 1 << $urandom_range(14, 4);
            s.v0_x = $signed(16'($urandom_range(span))) - 16'(span / 2);
            s.v0_y = $signed(16'($urandom_range(span))) - 16'(span / 2);
            s.v1_x = s.v0_x + 16'($urandom_range(span));
            s.v1_y = s.v0_y + 16'($urandom_range(span / 4));
            s.v2_x = s.v0_x + 16'($urandom_range(span / 4));
            s.v2_y = s.v0_y + 16'($urandom_range(span));
            s.pixel_x = s.v0_x + 16'($urandom_range(span)) - 16'(span / 8);
            s.pixel_y = s.v0_y + 16'($urandom_range(span)) - 16'(span / 8);
            s.v0_w = 32'($urandom_range(32'h7fff_ffff, 1) >> $urandom_range(20));
            s.v1_w = 32'($urandom_range(32'h7fff_ffff, 1) >> $urandom_range(20));
            s.v2_w = 32'($urandom_range(32'h7fff_ffff, 1) >> $urandom_range(20));
         end
         3: begin
            // collinear vertices
            s.v2_x = s.v1_x;
            s.v2_y = s.v1_y;
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic run_phase(int n, int idle, int stall, logic [pbw_pkg::EPS_W-1:0] eps);
      // block is idle here; wait out any in-flight work before the register write
      repeat (LATENCY + 4) @(posedge clock);
      csr_write_value <= eps;
      csr_write_go    <= 1'b1;
      @(posedge clock iff (csr_ch.valid && csr_ch.ready));
      csr_write_go <= 1'b0;
      @(posedge clock);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) pending_samples.push_back(random_sample());
      while (pending_samples.size() > 0 || req_ch.valid || expected_weights.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      pbw_pkg::req_type s;
      model_epsilon = pbw_pkg::EPS_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero area, zero normalizer, saturation, inside boundary
      s = '0;
      pending_samples.push_back(s);
      s = '0; s.v1_x = 16; s.v2_y = 16; s.v0_w = 32'h10000; s.v1_w = 32'h10000;
      s.v2_w = 32'h10000; s.pixel_x = 4; s.pixel_y = 4;
      pending_samples.push_back(s);
      s.v0_w = 0; s.v1_w = 0; s.v2_w = 0;
      pending_samples.push_back(s);
      s.v0_w = 32'h7fff_ffff; s.v1_w = 32'h8000_0000; s.v2_w = 32'hffff_ffff;
      pending_samples.push_back(s);
      s = '0; s.v1_x = 1; s.v2_y = 1; s.pixel_x = 16'sh7fff; s.pixel_y = 16'sh8000;
      s.v0_w = 32'h10000; s.v1_w = 32'h20000; s.v2_w = 32'h30000;
      pending_samples.push_back(s);
      s.pixel_x = -1; s.pixel_y = 0;
      pending_samples.push_back(s);
      s = '0; s.v0_x = 16'sh8000; s.v0_y = 16'sh8000; s.v1_x = 16'sh7fff; s.v1_y = 16'sh8000;
      s.v2_x = 16'sh8000; s.v2_y = 16'sh7fff; s.pixel_x = 0; s.pixel_y = 0;
      s.v0_w = 32'h8000_0000; s.v1_w = 32'h7fff_ffff; s.v2_w = 1;
      pending_samples.push_back(s);
      s.pixel_x = 16'sh7fff; s.pixel_y = 16'sh7fff;
      pending_samples.push_back(s);
      s = '1;
      pending_samples.push_back(s);
      // normalizer cancels: w0 = -w1 with equal screen weights
      s = '0; s.v1_x = 32; s.v2_y = 32; s.pixel_x = 16; s.pixel_y = 0;
      s.v0_w = 32'h10000; s.v1_w = -32'sh10000; s.v2_w = 32'h10000;
      pending_samples.push_back(s);
      while (pending_samples.size() > 0 || req_ch.valid || expected_weights.size() > 0)
         @(posedge clock);

      run_phase(90, 0, 0, 16'h0000);
      run_phase(90, 87, 0, 16'hffff);
      run_phase(90, 0, 87, 16'h0100);
      run_phase(90, 16, 16, 16'h0001);
      run_phase(90, 0, 0, 16'($urandom));

      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_weights.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pbw_pkg.sv
rtl/pbw_req_if.sv
rtl/pbw_rsp_if.sv
rtl/pbw_csr_if.sv
rtl/pbw_setup.sv
rtl/pbw_div.sv
rtl/pbw_norm.sv
rtl/perspective_barycentric_weights.sv
tb/perspective_barycentric_weights_test.sv
